// File: src/gyro_rate_deadband_integrator_core_defines.svh
// assertion macros for the gyro rate integrator top level
`ifndef GYRO_RATE_DEADBAND_INTEGRATOR_CORE_DEFINES_SVH
`define GYRO_RATE_DEADBAND_INTEGRATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk and held off during rst
`define GRDI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and held off during rst
`define GRDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/grdi_pkg.sv
// shared constants, lane control types and register indexes
package grdi_pkg;

  // calibration run length, a power of two
  localparam int CAL_SAMPLES = 512;
  localparam int CAL_LOG     = $clog2(CAL_SAMPLES);
  localparam int CNT_W       = CAL_LOG;

  localparam int AXES    = 3;
  localparam int RAW_W   = 16;
  localparam int SUM_W   = RAW_W + CAL_LOG;
  localparam int SQ_W    = 2 * RAW_W - 1 + CAL_LOG;
  localparam int VAR_W   = 2 * RAW_W - 1;
  localparam int ROOT_W  = 16;
  localparam int THR_W   = ROOT_W + 4;
  localparam int THR_MAX = 32767;

  localparam int DPS_W   = 16;
  localparam int SIG_W   = 4;
  localparam int MS_W    = 16;
  localparam int MAG_W   = 32;
  localparam int RATE_W  = 33;
  localparam int ANGLE_W = 48;
  localparam int PROD_W  = MAG_W + MS_W;

  // divide by 1000 one 16-bit chunk at a time, reciprocal 2^36 / 1000 rounded up
  localparam int DIV_CHUNK = 16;
  localparam int DIV_STEPS = PROD_W / DIV_CHUNK;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIV_REM_W = 10;
  localparam int DIV_V_W   = DIV_REM_W + DIV_CHUNK;
  localparam int DIV_M_W   = 27;
  localparam int DIV_K     = 36;
  localparam logic [DIV_M_W-1:0] DIV_M = 27'd68719477;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DPS_SCALE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MULTIPLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL_MS = 2'd2;
  localparam logic [DPS_W-1:0] DPS_SCALE_RST       = 16'd573;
  localparam logic [SIG_W-1:0] SIGMA_MULTIPLE_RST  = 4'd3;
  localparam logic [MS_W-1:0]  MAX_INTERVAL_MS_RST = 16'd300;

  // lane operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE      = 4'd0;
  localparam logic [OP_W-1:0] OP_CAL       = 4'd1;
  localparam logic [OP_W-1:0] OP_FIN_MEAN  = 4'd2;
  localparam logic [OP_W-1:0] OP_FIN_SQ    = 4'd3;
  localparam logic [OP_W-1:0] OP_FIN_VAR   = 4'd4;
  localparam logic [OP_W-1:0] OP_FIN_THR   = 4'd5;
  localparam logic [OP_W-1:0] OP_MEAS_RATE = 4'd6;
  localparam logic [OP_W-1:0] OP_MEAS_PROD = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV       = 4'd8;
  localparam logic [OP_W-1:0] OP_MEAS_ADD  = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DPS_W-1:0] dps_scale;
    logic [SIG_W-1:0] sigma_multiple;
    logic [MS_W-1:0]  dt;
  } lane_cmd_t;

  typedef struct packed {
    logic root_busy;
  } lane_stat_t;

  typedef struct packed {
    logic signed [RATE_W-1:0]  rate;
    logic signed [ANGLE_W-1:0] angle;
  } lane_res_t;

endpackage

// File: src/grdi_if.sv
// sample, result and configuration channel interfaces
interface grdi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [grdi_pkg::RAW_W-1:0]   raw_x;
  logic signed [grdi_pkg::RAW_W-1:0]   raw_y;
  logic signed [grdi_pkg::RAW_W-1:0]   raw_z;
  logic [grdi_pkg::MS_W-1:0]           elapsed_ms;
  modport source (output valid, command, raw_x, raw_y, raw_z, elapsed_ms, input ready);
  modport sink (input valid, command, raw_x, raw_y, raw_z, elapsed_ms, output ready);
endinterface

interface grdi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [grdi_pkg::RATE_W-1:0]  rate_x;
  logic signed [grdi_pkg::RATE_W-1:0]  rate_y;
  logic signed [grdi_pkg::RATE_W-1:0]  rate_z;
  logic signed [grdi_pkg::ANGLE_W-1:0] angle_x;
  logic signed [grdi_pkg::ANGLE_W-1:0] angle_y;
  logic signed [grdi_pkg::ANGLE_W-1:0] angle_z;
  logic                                calibrated;
  modport source (output valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                  calibrated, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                calibrated, output ready);
endinterface

interface grdi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [grdi_pkg::CFG_IDX_W-1:0]    index;
  logic [grdi_pkg::DPS_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/grdi_isqrt.sv
// iterative integer square root, one result bit per cycle
module grdi_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [2*grdi_pkg::ROOT_W-1:0]   operand,
  output logic                            busy,
  output logic [grdi_pkg::ROOT_W-1:0]     root
);

  localparam int REM_W = grdi_pkg::ROOT_W + 4;
  localparam int CNT_W = $clog2(grdi_pkg::ROOT_W + 1);

  logic [2*grdi_pkg::ROOT_W-1:0] x;
  logic [REM_W-1:0]              rem;
  logic [CNT_W-1:0]              cnt;
  logic [REM_W-1:0]              rem_sh;
  logic [REM_W-1:0]              trial;
  logic                          ge;

  // bring down the next two operand bits and try the next root bit
  always_comb begin
    rem_sh = {rem[REM_W-3:0], x[2*grdi_pkg::ROOT_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    ge     = (rem_sh >= trial);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(grdi_pkg::ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= {x[2*grdi_pkg::ROOT_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[grdi_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// File: src/grdi_lane.sv
// one axis: calibration sums, zero rate, deadband, scaling and heading
module grdi_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  grdi_pkg::lane_cmd_t               cmd,
  input  logic signed [grdi_pkg::RAW_W-1:0] raw,
  output grdi_pkg::lane_stat_t              stat,
  output grdi_pkg::lane_res_t               res
);

  localparam int RAW_W = grdi_pkg::RAW_W;
  localparam int SUM_W = grdi_pkg::SUM_W;
  localparam int SQ_W  = grdi_pkg::SQ_W;
  localparam int VAR_W = grdi_pkg::VAR_W;
  localparam int V_W   = grdi_pkg::DIV_V_W;

  // architectural state
  logic signed [SUM_W-1:0]                cal_sum;
  logic [SQ_W-1:0]                        cal_sum_squares;
  logic signed [RAW_W-1:0]                zero_rate;
  logic [RAW_W-1:0]                       deadband;
  logic [grdi_pkg::ANGLE_W-1:0]           angle;

  // working registers
  logic signed [RAW_W-1:0]                mean;
  logic [VAR_W-1:0]                       msq;
  logic signed [2*RAW_W-1:0]              m2;
  logic [grdi_pkg::MAG_W-1:0]             rate_mag;
  logic                                   neg;
  logic signed [grdi_pkg::RATE_W-1:0]     rate;
  logic [grdi_pkg::PROD_W-1:0]            prod;
  logic [grdi_pkg::PROD_W-1:0]            quo;
  logic [grdi_pkg::DIV_REM_W-1:0]         rem;

  // combinational terms
  logic signed [2*RAW_W-1:0]              raw_sq;
  logic signed [SUM_W-1:0]                sum_adj;
  logic signed [SUM_W-1:0]                sum_shift;
  logic [VAR_W-1:0]                       var_val;
  logic                                   root_busy;
  logic [grdi_pkg::ROOT_W-1:0]            root;
  logic [grdi_pkg::THR_W-1:0]             thr;
  logic signed [RAW_W:0]                  delta;
  logic [RAW_W:0]                         delta_abs;
  logic [RAW_W-1:0]                       mag_kept;
  logic [V_W-1:0]                         div_v;
  logic [V_W+grdi_pkg::DIV_M_W-1:0]       div_p;
  logic [grdi_pkg::DIV_CHUNK-1:0]         div_q;
  logic [V_W-1:0]                         div_qx;
  logic [V_W-1:0]                         div_r;

  // calibration terms: square, truncated mean, variance, threshold
  always_comb begin
    raw_sq    = raw * raw;
    sum_adj   = cal_sum + (cal_sum[SUM_W-1] ? SUM_W'(grdi_pkg::CAL_SAMPLES - 1) : '0);
    sum_shift = sum_adj >>> grdi_pkg::CAL_LOG;
    var_val   = (msq > m2[VAR_W-1:0]) ? (msq - m2[VAR_W-1:0]) : '0;
    thr       = cmd.sigma_multiple * root;
  end

  // measure terms: offset, deadband test
  always_comb begin
    delta     = {raw[RAW_W-1], raw} - {zero_rate[RAW_W-1], zero_rate};
    delta_abs = delta[RAW_W] ? (RAW_W+1)'(-delta) : delta;
    mag_kept  = (delta_abs[RAW_W-1:0] < deadband) ? '0 : delta_abs[RAW_W-1:0];
  end

  // one chunk of the divide by 1000 (1000 = 1024 - 16 - 8)
  always_comb begin
    div_v  = {rem, prod[grdi_pkg::PROD_W-1 -: grdi_pkg::DIV_CHUNK]};
    div_p  = div_v * grdi_pkg::DIV_M;
    div_q  = div_p[grdi_pkg::DIV_K +: grdi_pkg::DIV_CHUNK];
    div_qx = V_W'({div_q, 10'd0}) - V_W'({div_q, 4'd0}) - V_W'({div_q, 3'd0});
    div_r  = div_v - div_qx;
  end

  grdi_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == grdi_pkg::OP_FIN_VAR),
    .operand ({1'b0, var_val}),
    .busy    (root_busy),
    .root    (root)
  );

  // calibration state, zero rate, deadband and heading
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_sum         <= '0;
      cal_sum_squares <= '0;
      zero_rate       <= '0;
      deadband        <= '0;
      angle           <= '0;
    end else begin
      case (cmd.op)
        grdi_pkg::OP_CAL: begin
          cal_sum         <= cal_sum + {{(SUM_W-RAW_W){raw[RAW_W-1]}}, raw};
          cal_sum_squares <= cal_sum_squares + {{(SQ_W-2*RAW_W){1'b0}}, raw_sq};
        end
        grdi_pkg::OP_FIN_THR: begin
          zero_rate       <= mean;
          deadband        <= (thr > grdi_pkg::THR_W'(grdi_pkg::THR_MAX)) ?
                             RAW_W'(grdi_pkg::THR_MAX) : thr[RAW_W-1:0];
          cal_sum         <= '0;
          cal_sum_squares <= '0;
        end
        grdi_pkg::OP_MEAS_ADD: begin
          angle <= neg ? (angle - quo) : (angle + quo);
        end
        default: begin
        end
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      grdi_pkg::OP_CAL: begin
        rate <= '0;
      end
      grdi_pkg::OP_FIN_MEAN: begin
        mean <= sum_shift[RAW_W-1:0];
        msq  <= cal_sum_squares[SQ_W-1:grdi_pkg::CAL_LOG];
      end
      grdi_pkg::OP_FIN_SQ: begin
        m2 <= mean * mean;
      end
      grdi_pkg::OP_MEAS_RATE: begin
        rate_mag <= cmd.dps_scale * mag_kept;
        neg      <= delta[RAW_W];
      end
      grdi_pkg::OP_MEAS_PROD: begin
        prod <= rate_mag * cmd.dt;
        rem  <= '0;
        rate <= neg ? -grdi_pkg::RATE_W'(rate_mag) : grdi_pkg::RATE_W'(rate_mag);
      end
      grdi_pkg::OP_DIV: begin
        prod <= {prod[grdi_pkg::PROD_W-grdi_pkg::DIV_CHUNK-1:0],
                 {grdi_pkg::DIV_CHUNK{1'b0}}};
        quo  <= {quo[grdi_pkg::PROD_W-grdi_pkg::DIV_CHUNK-1:0], div_q};
        rem  <= div_r[grdi_pkg::DIV_REM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign stat.root_busy = root_busy;
  assign res.rate       = rate;
  assign res.angle      = angle;

endmodule

// File: src/grdi_merge.sv
// gathers the three lane results into one output transaction register
module grdi_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  grdi_pkg::lane_res_t  lane_res [grdi_pkg::AXES],
  input  logic                 calibrated,
  output logic                 space,
  grdi_out_if.source           result
);

  assign space = !result.valid || result.ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      result.rate_x     <= lane_res[0].rate;
      result.rate_y     <= lane_res[1].rate;
      result.rate_z     <= lane_res[2].rate;
      result.angle_x    <= lane_res[0].angle;
      result.angle_y    <= lane_res[1].angle;
      result.angle_z    <= lane_res[2].angle;
      result.calibrated <= calibrated;
    end
  end

endmodule

// File: src/gyro_rate_deadband_integrator_core.sv
// gyro zero-rate calibration, deadband and heading integration, top level
// one item at a time; the three axes run in parallel lanes
// measure item: rate, product, chunked divide, heading add, then the output register
// calibration item: sums; a run's closing item adds mean, variance, root, threshold
// synchronous active-high reset clears sums, zero rates, deadbands, headings; cfg to reset
`include "gyro_rate_deadband_integrator_core_defines.svh"

module gyro_rate_deadband_integrator_core (
  input  logic        clk,
  input  logic        rst,
  grdi_in_if.sink     sample,
  grdi_out_if.source  result,
  grdi_cfg_if.sink    cfg
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
  localparam logic [ST_W-1:0] S_CAL       = 4'd1;
  localparam logic [ST_W-1:0] S_FIN_MEAN  = 4'd2;
  localparam logic [ST_W-1:0] S_FIN_SQ    = 4'd3;
  localparam logic [ST_W-1:0] S_FIN_VAR   = 4'd4;
  localparam logic [ST_W-1:0] S_FIN_WAIT  = 4'd5;
  localparam logic [ST_W-1:0] S_FIN_THR   = 4'd6;
  localparam logic [ST_W-1:0] S_MEAS_RATE = 4'd7;
  localparam logic [ST_W-1:0] S_MEAS_PROD = 4'd8;
  localparam logic [ST_W-1:0] S_DIV       = 4'd9;
  localparam logic [ST_W-1:0] S_MEAS_ADD  = 4'd10;
  localparam logic [ST_W-1:0] S_OUT       = 4'd11;

  logic [ST_W-1:0]                     state;
  logic [grdi_pkg::CNT_W-1:0]          cal_count;
  logic                                cal_done;
  logic [grdi_pkg::DIV_CNT_W-1:0]      div_cnt;
  logic [grdi_pkg::DPS_W-1:0]          dps_scale;
  logic [grdi_pkg::SIG_W-1:0]          sigma_multiple;
  logic [grdi_pkg::MS_W-1:0]           max_interval_ms;
  logic signed [grdi_pkg::RAW_W-1:0]   raw [grdi_pkg::AXES];
  logic [grdi_pkg::MS_W-1:0]           dt;

  grdi_pkg::lane_cmd_t                 lane_cmd;
  grdi_pkg::lane_stat_t                lane_stat [grdi_pkg::AXES];
  grdi_pkg::lane_res_t                 lane_res [grdi_pkg::AXES];
  logic                                busy_any;
  logic                                out_space;
  logic                                out_load;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign out_load     = (state == S_OUT) && out_space;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dps_scale       <= grdi_pkg::DPS_SCALE_RST;
      sigma_multiple  <= grdi_pkg::SIGMA_MULTIPLE_RST;
      max_interval_ms <= grdi_pkg::MAX_INTERVAL_MS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        grdi_pkg::REG_DPS_SCALE:       dps_scale       <= cfg.data;
        grdi_pkg::REG_SIGMA_MULTIPLE:  sigma_multiple  <= cfg.data[grdi_pkg::SIG_W-1:0];
        grdi_pkg::REG_MAX_INTERVAL_MS: max_interval_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // capture the accepted transaction, long intervals count as zero
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      raw[0] <= sample.raw_x;
      raw[1] <= sample.raw_y;
      raw[2] <= sample.raw_z;
      dt     <= (sample.elapsed_ms > max_interval_ms) ? '0 : sample.elapsed_ms;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cal_count <= '0;
      cal_done  <= 1'b0;
      div_cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= sample.command ? S_MEAS_RATE : S_CAL;
          end
        end
        S_CAL: begin
          if (cal_count == grdi_pkg::CNT_W'(grdi_pkg::CAL_SAMPLES - 1)) begin
            cal_count <= '0;
            state     <= S_FIN_MEAN;
          end else begin
            cal_count <= cal_count + 1'b1;
            state     <= S_OUT;
          end
        end
        S_FIN_MEAN: state <= S_FIN_SQ;
        S_FIN_SQ:   state <= S_FIN_VAR;
        S_FIN_VAR:  state <= S_FIN_WAIT;
        S_FIN_WAIT: begin
          if (!busy_any) begin
            state <= S_FIN_THR;
          end
        end
        S_FIN_THR: begin
          cal_done <= 1'b1;
          state    <= S_OUT;
        end
        S_MEAS_RATE: state <= S_MEAS_PROD;
        S_MEAS_PROD: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == grdi_pkg::DIV_CNT_W'(grdi_pkg::DIV_STEPS - 1)) begin
            state <= S_MEAS_ADD;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_MEAS_ADD: state <= S_OUT;
        S_OUT: begin
          if (out_space) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // lane command from the sequencer state
  always_comb begin
    lane_cmd.dps_scale      = dps_scale;
    lane_cmd.sigma_multiple = sigma_multiple;
    lane_cmd.dt             = dt;
    case (state)
      S_CAL:       lane_cmd.op = grdi_pkg::OP_CAL;
      S_FIN_MEAN:  lane_cmd.op = grdi_pkg::OP_FIN_MEAN;
      S_FIN_SQ:    lane_cmd.op = grdi_pkg::OP_FIN_SQ;
      S_FIN_VAR:   lane_cmd.op = grdi_pkg::OP_FIN_VAR;
      S_FIN_THR:   lane_cmd.op = grdi_pkg::OP_FIN_THR;
      S_MEAS_RATE: lane_cmd.op = grdi_pkg::OP_MEAS_RATE;
      S_MEAS_PROD: lane_cmd.op = grdi_pkg::OP_MEAS_PROD;
      S_DIV:       lane_cmd.op = grdi_pkg::OP_DIV;
      S_MEAS_ADD:  lane_cmd.op = grdi_pkg::OP_MEAS_ADD;
      default:     lane_cmd.op = grdi_pkg::OP_IDLE;
    endcase
  end

  // axis lanes
  for (genvar j = 0; j < grdi_pkg::AXES; j++) begin : g_lane
    grdi_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (lane_cmd),
      .raw  (raw[j]),
      .stat (lane_stat[j]),
      .res  (lane_res[j])
    );
  end

  // any square root still running
  always_comb begin
    busy_any = 1'b0;
    for (int j = 0; j < grdi_pkg::AXES; j++) begin
      busy_any = busy_any | lane_stat[j].root_busy;
    end
  end

  grdi_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .lane_res   (lane_res),
    .calibrated (cal_done),
    .space      (out_space),
    .result     (result)
  );

  // checks
  `GRDI_ASSERT_IMPL(a_idle_roots_quiet, state == S_IDLE, !busy_any, "square root busy while idle")
  `GRDI_ASSERT_NEXT(a_run_restarts, state == S_FIN_THR, cal_done && cal_count == '0, "run did not close")
  `GRDI_ASSERT_NEXT(a_cal_done_sticky, cal_done, cal_done, "calibrated flag dropped")

endmodule

// File: verif/gyro_rate_deadband_integrator_core_tb.sv
// self-checking testbench for the gyro rate deadband integrator with a built-in heading predictor
module gyro_rate_deadband_integrator_core_tb;
  import grdi_pkg::*;

  localparam logic CMD_CAL     = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;
  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic                     command;
    logic signed [RAW_W-1:0]  raw_x;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_z;
    logic [MS_W-1:0]          elapsed_ms;
  } gyro_sample_t;

  typedef struct packed {
    logic [AXES-1:0][RATE_W-1:0]  rate;
    logic [AXES-1:0][ANGLE_W-1:0] angle;
    logic                         calibrated;
  } heading_report_t;

  logic clk;
  logic rst;

  grdi_in_if  sample_bus ();
  grdi_out_if result_bus ();
  grdi_cfg_if cfg_bus ();

  gyro_rate_deadband_integrator_core uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // stimulus backlog, predicted reports, pacing and bookkeeping
  gyro_sample_t    samples_to_send[$];
  heading_report_t predicted_headings[$];
  gyro_sample_t    on_bus;
  heading_report_t seen;
  heading_report_t want;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int cal_items_queued = 0;

  // predictor registers and state
  logic [DPS_W-1:0] scale_reg = DPS_SCALE_RST;
  logic [SIG_W-1:0] sigma_reg = SIGMA_MULTIPLE_RST;
  logic [MS_W-1:0]  gap_limit_reg = MAX_INTERVAL_MS_RST;
  longint run_sum [AXES];
  longint run_sq [AXES];
  int     run_len = 0;
  int     bias_est [AXES];
  int     deadband_est [AXES];
  logic [ANGLE_W-1:0] heading [AXES];
  logic   calibration_done = 1'b0;

  // calibration sample profile: negative noise means full-range samples
  int prof_bias [AXES];
  int prof_noise [AXES];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // largest root whose square does not exceed v
  function automatic longint int_sqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // advance the predicted state by one accepted sample and return its report
  function automatic heading_report_t integrate_sample(input gyro_sample_t s);
    heading_report_t r;
    longint raw [AXES];
    longint mean, msq, m2, spread, thr, dt, delta, mag, rate, step;
    r = '0;
    raw[0] = s.raw_x;
    raw[1] = s.raw_y;
    raw[2] = s.raw_z;
    if (s.command == CMD_CAL) begin
      for (int j = 0; j < AXES; j++) begin
        run_sum[j] += raw[j];
        run_sq[j] += raw[j] * raw[j];
      end
      run_len++;
      // run complete: truncated mean and scaled root of the variance
      if (run_len == CAL_SAMPLES) begin
        for (int j = 0; j < AXES; j++) begin
          mean = run_sum[j] / CAL_SAMPLES;
          msq = run_sq[j] / CAL_SAMPLES;
          m2 = mean * mean;
          spread = (msq > m2) ? msq - m2 : 0;
          thr = longint'(sigma_reg) * int_sqrt(spread);
          if (thr > THR_MAX) thr = THR_MAX;
          bias_est[j] = mean;
          deadband_est[j] = thr;
          run_sum[j] = 0;
          run_sq[j] = 0;
        end
        run_len = 0;
        calibration_done = 1'b1;
      end
    end else begin
      dt = (s.elapsed_ms > gap_limit_reg) ? 0 : s.elapsed_ms;
      for (int j = 0; j < AXES; j++) begin
        delta = raw[j] - bias_est[j];
        mag = (delta < 0) ? -delta : delta;
        if (mag < deadband_est[j]) delta = 0;
        rate = longint'(scale_reg) * delta;
        step = (rate * dt) / 1000;
        heading[j] = heading[j] + step[ANGLE_W-1:0];
        r.rate[j] = rate[RATE_W-1:0];
      end
    end
    for (int j = 0; j < AXES; j++) r.angle[j] = heading[j];
    r.calibrated = calibration_done;
    return r;
  endfunction

  function automatic void queue_sample(input logic cmd, input logic signed [RAW_W-1:0] x,
                                       input logic signed [RAW_W-1:0] y,
                                       input logic signed [RAW_W-1:0] z,
                                       input logic [MS_W-1:0] ms);
    gyro_sample_t s;
    s.command = cmd;
    s.raw_x = x;
    s.raw_y = y;
    s.raw_z = z;
    s.elapsed_ms = ms;
    samples_to_send.push_back(s);
    if (cmd == CMD_CAL) cal_items_queued = (cal_items_queued + 1) % CAL_SAMPLES;
  endfunction

  function automatic void set_profile(input int b0, input int n0, input int b1, input int n1,
                                      input int b2, input int n2);
    prof_bias[0] = b0;
    prof_noise[0] = n0;
    prof_bias[1] = b1;
    prof_noise[1] = n1;
    prof_bias[2] = b2;
    prof_noise[2] = n2;
  endfunction

  // calibration value: bias plus uniform noise, clamped to the raw range
  function automatic logic signed [RAW_W-1:0] draw_cal(input int j);
    int v;
    int off;
    if (prof_noise[j] < 0) return $urandom_range(0, 65535);
    off = $urandom_range(0, 2 * prof_noise[j]);
    v = prof_bias[j] + off - prof_noise[j];
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[RAW_W-1:0];
  endfunction

  // measure value: mostly around the current zero rate and deadband edge
  function automatic logic signed [RAW_W-1:0] draw_meas(input int j);
    int v;
    int pick;
    int sgn;
    int jit;
    pick = $urandom_range(0, 9);
    sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
    if (pick < 4) return $urandom_range(0, 65535);
    if (pick < 8) begin
      jit = $urandom_range(0, 2);
      v = bias_est[j] + sgn * (deadband_est[j] + jit - 1);
    end else if (pick == 8) begin
      v = bias_est[j];
    end else begin
      jit = $urandom_range(0, deadband_est[j] + 64);
      v = bias_est[j] + sgn * jit;
    end
    if (v > 32767 || v < -32768) return $urandom_range(0, 65535);
    return v[RAW_W-1:0];
  endfunction

  // interval: around the limit, zero, small, or anything
  function automatic logic [MS_W-1:0] draw_elapsed();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return $urandom_range(0, gap_limit_reg);
      4:          return gap_limit_reg;
      5:          return gap_limit_reg + 1;
      6, 7:       return $urandom_range(0, 65535);
      8:          return '0;
      default:    return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic void queue_meas();
    queue_sample(CMD_MEASURE, draw_meas(0), draw_meas(1), draw_meas(2), draw_elapsed());
  endfunction

  function automatic void queue_cal();
    queue_sample(CMD_CAL, draw_cal(0), draw_cal(1), draw_cal(2), $urandom_range(0, 65535));
  endfunction

  function automatic void queue_mix(input int n, input int cal_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < cal_pct) queue_cal();
      else queue_meas();
    end
  endfunction

  // calibration items up to the end of the open run, measures interleaved
  function automatic void queue_run_rest(input int meas_pct);
    do begin
      if ($urandom_range(0, 99) < meas_pct) queue_meas();
      else queue_cal();
    end while (cal_items_queued != 0);
  endfunction

  task automatic set_pace(input int send_gap, input int stall);
    @(negedge clk);
    send_idle_pct = send_gap;
    stall_pct = stall;
  endtask

  // wait until every sample is sent and every report is back, then let the core go quiet
  task automatic settle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || sample_bus.valid || predicted_headings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write transaction, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DPS_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_DPS_SCALE:       scale_reg = val;
      REG_SIGMA_MULTIPLE:  sigma_reg = val[SIG_W-1:0];
      REG_MAX_INTERVAL_MS: gap_limit_reg = val;
      default: ;
    endcase
  endtask

  // sample driver: holds each transaction until accepted
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready)
        predicted_headings.push_back(integrate_sample(on_bus));
      if (!sample_bus.valid || sample_bus.ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = samples_to_send.pop_front();
          sample_bus.valid <= 1'b1;
          sample_bus.command <= on_bus.command;
          sample_bus.raw_x <= on_bus.raw_x;
          sample_bus.raw_y <= on_bus.raw_y;
          sample_bus.raw_z <= on_bus.raw_z;
          sample_bus.elapsed_ms <= on_bus.elapsed_ms;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        seen.rate[0] = result_bus.rate_x;
        seen.rate[1] = result_bus.rate_y;
        seen.rate[2] = result_bus.rate_z;
        seen.angle[0] = result_bus.angle_x;
        seen.angle[1] = result_bus.angle_y;
        seen.angle[2] = result_bus.angle_z;
        seen.calibrated = result_bus.calibrated;
        if (predicted_headings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, seen);
        end else begin
          want = predicted_headings.pop_front();
          for (int j = 0; j < AXES; j++) begin
            if (seen.rate[j] !== want.rate[j]) begin
              mismatches++;
              $display("%0t: axis %0d rate expected %0d, got %0d", $time, j,
                       $signed(want.rate[j]), $signed(seen.rate[j]));
            end
            if (seen.angle[j] !== want.angle[j]) begin
              mismatches++;
              $display("%0t: axis %0d angle expected %0d, got %0d", $time, j,
                       $signed(want.angle[j]), $signed(seen.angle[j]));
            end
          end
          if (seen.calibrated !== want.calibrated) begin
            mismatches++;
            $display("%0t: calibrated expected %0b, got %0b", $time,
                     want.calibrated, seen.calibrated);
          end
        end
      end
      result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    sample_bus.valid = 1'b0;
    sample_bus.command = CMD_CAL;
    sample_bus.raw_x = '0;
    sample_bus.raw_y = '0;
    sample_bus.raw_z = '0;
    sample_bus.elapsed_ms = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_DPS_SCALE;
    cfg_bus.data = '0;
    for (int j = 0; j < AXES; j++) begin
      run_sum[j] = 0;
      run_sq[j] = 0;
      bias_est[j] = 0;
      deadband_est[j] = 0;
      heading[j] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero offset and deadband before calibration, interval limit, extremes
    set_pace(0, 0);
    queue_sample(CMD_MEASURE, 0, 0, 0, 0);
    queue_sample(CMD_MEASURE, RAW_MAX, RAW_MIN, -1, 300);
    queue_sample(CMD_MEASURE, RAW_MIN, RAW_MAX, 1, 301);
    queue_sample(CMD_MEASURE, RAW_MAX, RAW_MAX, RAW_MAX, 16'hFFFF);
    queue_sample(CMD_MEASURE, RAW_MIN, RAW_MIN, RAW_MIN, 299);
    queue_sample(CMD_MEASURE, 1, -1, 16'sh5555, 16'hAAAA);
    queue_sample(CMD_MEASURE, 16'shAAAA, 16'sh2AAA, 7, 1);
    queue_sample(CMD_MEASURE, -7, 3, -1000, 3);
    queue_sample(CMD_MEASURE, 1000, -999, 0, 1000);
    // calibration items keep x pinned at the minimum for a zero-spread axis
    queue_sample(CMD_CAL, RAW_MIN, RAW_MAX, RAW_MIN, 16'h5555);
    queue_sample(CMD_CAL, RAW_MIN, RAW_MIN, RAW_MAX, 16'hAAAA);
    queue_sample(CMD_CAL, RAW_MIN, 0, -1, 0);
    queue_sample(CMD_MEASURE, 123, -456, 789, 16'h5555);
    queue_sample(CMD_MEASURE, 0, 0, 0, 300);
    settle();
    write_reg(REG_SIGMA_MULTIPLE, 15);

    // first run: constant x, full-range y saturates, moderate z
    set_profile(-32768, 0, 0, -1, int'($urandom_range(0, 8000)) - 4000, 1000);
    set_pace(0, 0);
    queue_mix(150, 70);
    settle();
    set_pace(61, 0);
    queue_run_rest(20);
    settle();
    write_reg(REG_DPS_SCALE, 16'hFFFF);
    write_reg(REG_MAX_INTERVAL_MS, 16'hFFFF);

    // heading wrap: largest rate on x with long intervals
    set_pace(0, 61);
    for (int i = 0; i < 560; i++)
      queue_sample(CMD_MEASURE, RAW_MAX, draw_meas(1), draw_meas(2),
                   $urandom_range(60000, 65535));
    queue_mix(40, 0);
    settle();
    write_reg(REG_SIGMA_MULTIPLE, 0);
    write_reg(REG_DPS_SCALE, 0);
    write_reg(REG_MAX_INTERVAL_MS, 0);

    // second run, closed with a zero sigma multiple
    set_profile(int'($urandom_range(0, 40000)) - 20000, 40,
                int'($urandom_range(0, 60000)) - 30000, 500,
                int'($urandom_range(0, 8000)) - 4000, 0);
    set_pace(16, 16);
    queue_mix(30, 0);
    for (int i = 0; i < 40; i++) queue_cal();
    settle();
    write_reg(REG_DPS_SCALE, $urandom_range(1, 65534));
    write_reg(REG_MAX_INTERVAL_MS, $urandom_range(100, 3000));
    set_pace(16, 16);
    queue_run_rest(20);
    settle();
    write_reg(REG_SIGMA_MULTIPLE, 1);
    write_reg(REG_DPS_SCALE, $urandom_range(1, 65534));
    write_reg(REG_MAX_INTERVAL_MS, 300);

    // third run left open while measuring with the second run's values
    set_profile(int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 3000),
                int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 3000),
                int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 3000));
    set_pace(0, 61);
    queue_mix(100, 50);
    settle();

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
